FILE: rtl/swlb_pkg.sv
// shared sizes and types of the sliding window line buffer
package swlb_pkg;

	localparam int KERNEL_ROWS = 3;
	localparam int KERNEL_COLS = 3;
	localparam int LINE_WIDTH  = 64;
	localparam int DATA_WIDTH  = 16;

	// fixed size of the result window and of the port fields
	localparam int MAX_ROWS  = 3;
	localparam int MAX_COLS  = 3;
	localparam int TAP_COUNT = MAX_ROWS * MAX_COLS;
	localparam int FIELD_W   = 16;

	// line stores between neighboring window rows
	localparam bit HAS_STORE   = (KERNEL_ROWS > 1) && (LINE_WIDTH > KERNEL_COLS);
	localparam int STORE_DEPTH = HAS_STORE ? (LINE_WIDTH - KERNEL_COLS) : 1;
	localparam int STORE_ROWS  = (KERNEL_ROWS > 1) ? (KERNEL_ROWS - 1) : 1;
	localparam int STORE_W     = STORE_ROWS * DATA_WIDTH;
	localparam int POS_W       = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

	typedef logic [FIELD_W-1:0]    field_t;
	typedef logic [DATA_WIDTH-1:0] data_t;
	typedef logic [POS_W-1:0]      pos_t;
	typedef logic [STORE_W-1:0]    store_word_t;

endpackage

FILE: rtl/swlb_ram.sv
// generic single write port, single read port ram with registered read
module swlb_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                                          clk,
	input  logic                                          wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  wr_addr,
	input  logic [WIDTH-1:0]                              wr_data,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  rd_addr,
	output logic [WIDTH-1:0]                              rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

FILE: rtl/sliding_window_line_buffer.sv
// sliding window line buffer: tap window registers, line store ram, output skid stage
//
// One pixel per request enters the window at row 0 column 0 and every value moves
// one tap onward; the last tap of a row goes into the line store ahead of the next
// row and the store's oldest entry enters that row. The block takes one pixel every
// clock while pixel_stall is low: the line stores of all rows share one ram word,
// written at the current position while the entry of the next position is read ahead,
// so the registered ram read never holds a pixel back. Each pixel gives one window
// request on the output in the cycle after it is accepted when the output register is
// free; a pixel taken while a window is stalled on the output waits in the skid
// register until that window is taken. The output register plus the skid register
// let the input keep flowing while a window waits; pixel_stall rises only when both
// are full. After reset the line stores read as zero until the write position has
// gone once round the store (line width minus kernel columns pixels); no clearing
// pass is run, so the block takes pixels from the first clock after reset.
module sliding_window_line_buffer (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              pixel_valid,
	output logic              pixel_stall,
	input  swlb_pkg::field_t  pixel,
	output logic              window_valid,
	input  logic              window_stall,
	output swlb_pkg::field_t  tap_0,
	output swlb_pkg::field_t  tap_1,
	output swlb_pkg::field_t  tap_2,
	output swlb_pkg::field_t  tap_3,
	output swlb_pkg::field_t  tap_4,
	output swlb_pkg::field_t  tap_5,
	output swlb_pkg::field_t  tap_6,
	output swlb_pkg::field_t  tap_7,
	output swlb_pkg::field_t  tap_8
);

	import swlb_pkg::*;

	// window state
	data_t       taps_q   [MAX_ROWS][MAX_COLS];
	data_t       taps_nxt [MAX_ROWS][MAX_COLS];
	data_t       row_in   [MAX_ROWS];

	// line store access
	pos_t        pos_q;
	pos_t        pos_nxt;
	logic        wrapped_q;
	logic        accept;
	logic        pos_last;
	store_word_t ram_rdata;
	store_word_t ram_wdata;
	store_word_t store_rd;
	store_word_t wr_data_s1;
	logic        fwd_s1;

	// output stage
	field_t      win_nxt  [TAP_COUNT];
	field_t      out_q    [TAP_COUNT];
	field_t      skid_q   [TAP_COUNT];
	logic        out_valid_q;
	logic        skid_valid_q;
	logic        out_taken;

	assign pixel_stall = skid_valid_q;
	assign accept      = pixel_valid && !pixel_stall;
	assign out_taken   = out_valid_q && !window_stall;
	assign pos_last    = (pos_q == POS_W'(STORE_DEPTH - 1));

	// read-ahead address: next position once this pixel is taken
	always_comb begin
		pos_nxt = pos_q;
		if (accept && HAS_STORE) begin
			pos_nxt = pos_last ? '0 : pos_q + 1'b1;
		end
	end

	// line store ram, one lane per row boundary
	generate
		if (HAS_STORE) begin : g_store
			swlb_ram #(
				.WIDTH (STORE_W),
				.DEPTH (STORE_DEPTH)
			) u_ram (
				.clk     (clk),
				.wr_en   (accept),
				.wr_addr (pos_q),
				.wr_data (ram_wdata),
				.rd_addr (pos_nxt),
				.rd_data (ram_rdata)
			);
		end else begin : g_no_store
			assign ram_rdata = '0;
		end
	endgenerate

	// entries not yet written since reset read as zero; forward a write that
	// hit the address being read in the same cycle
	always_comb begin
		if (!wrapped_q) begin
			store_rd = '0;
		end else if (fwd_s1) begin
			store_rd = wr_data_s1;
		end else begin
			store_rd = ram_rdata;
		end
	end

	// window shift
	always_comb begin
		ram_wdata = '0;
		for (int r = 0; r < MAX_ROWS; r++) begin
			row_in[r] = '0;
		end
		row_in[0] = DATA_WIDTH'(pixel);
		for (int r = 1; r < MAX_ROWS; r++) begin
			if (r < KERNEL_ROWS) begin
				if (HAS_STORE) begin
					row_in[r] = store_rd[(r-1)*DATA_WIDTH +: DATA_WIDTH];
				end else begin
					row_in[r] = taps_q[r-1][KERNEL_COLS-1];
				end
			end
		end
		for (int r = 0; r < MAX_ROWS - 1; r++) begin
			if (r < KERNEL_ROWS - 1) begin
				ram_wdata[r*DATA_WIDTH +: DATA_WIDTH] = taps_q[r][KERNEL_COLS-1];
			end
		end
		for (int r = 0; r < MAX_ROWS; r++) begin
			for (int c = 0; c < MAX_COLS; c++) begin
				if (r >= KERNEL_ROWS || c >= KERNEL_COLS) begin
					taps_nxt[r][c] = '0;
				end else if (c == 0) begin
					taps_nxt[r][c] = row_in[r];
				end else begin
					taps_nxt[r][c] = taps_q[r][c-1];
				end
				win_nxt[r*MAX_COLS + c] = FIELD_W'(taps_nxt[r][c]);
			end
		end
	end

	// window taps and store position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < MAX_ROWS; r++) begin
				for (int c = 0; c < MAX_COLS; c++) begin
					taps_q[r][c] <= '0;
				end
			end
			pos_q     <= '0;
			wrapped_q <= 1'b0;
			fwd_s1    <= 1'b0;
		end else begin
			if (accept) begin
				taps_q <= taps_nxt;
				if (HAS_STORE && pos_last) begin
					wrapped_q <= 1'b1;
				end
			end
			pos_q  <= pos_nxt;
			fwd_s1 <= accept && (pos_q == pos_nxt);
		end
	end

	always_ff @(posedge clk) begin
		wr_data_s1 <= ram_wdata;
	end

	// output register and skid register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (skid_valid_q) begin
				if (out_taken) begin
					skid_valid_q <= 1'b0;
				end
			end else if (accept) begin
				if (!out_valid_q || !window_stall) begin
					out_valid_q <= 1'b1;
				end else begin
					skid_valid_q <= 1'b1;
				end
			end else if (out_taken) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_taken) begin
				out_q <= skid_q;
			end
		end else if (accept) begin
			if (!out_valid_q || !window_stall) begin
				out_q <= win_nxt;
			end else begin
				skid_q <= win_nxt;
			end
		end
	end

	assign window_valid = out_valid_q;
	assign tap_0 = out_q[0];
	assign tap_1 = out_q[1];
	assign tap_2 = out_q[2];
	assign tap_3 = out_q[3];
	assign tap_4 = out_q[4];
	assign tap_5 = out_q[5];
	assign tap_6 = out_q[6];
	assign tap_7 = out_q[7];
	assign tap_8 = out_q[8];

`ifndef SYNTHESIS
	// skid register only fills behind a full output register
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid holds a window while output register is empty");

	// store position stays inside the store
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= POS_W'(STORE_DEPTH - 1))
		else $error("line store position out of range");

	// the store is marked filled exactly when the position wraps
	a_wrap_at_zero: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(wrapped_q) |-> (pos_q == '0))
		else $error("line store marked filled away from wrap point");

	// a pixel taken against a stalled window lands in the skid register
	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && out_valid_q && window_stall) |=> skid_valid_q)
		else $error("window lost behind stalled output");

	// position holds while no pixel is accepted; it only moves with an accepted pixel
	a_pos_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> $stable(pos_q))
		else $error("line store position moved without a pixel");
`endif

endmodule

FILE: tb/sliding_window_line_buffer_tb.sv
// self-checking testbench of the sliding window line buffer, directed rows then random pixels
module sliding_window_line_buffer_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import swlb_pkg::*;

	// one window as nine packed fields, index k is tap_k
	typedef field_t [TAP_COUNT-1:0] window_t;

	// one row of the directed part; want is only used when typed is set
	typedef struct packed {
		field_t  px;
		bit      typed;
		window_t want;
	} step_row_t;

	localparam int DIRECTED_N   = 20;
	localparam int RANDOM_N     = 1600;
	localparam int HOLD_CYCLES  = 60;     // long receiver hold-off, fills the block
	localparam int HOLD_AT      = 300;    // windows taken when the hold-off starts
	localparam int QUIET_FROM   = 500;    // no idling on either side in this span
	localparam int QUIET_TO     = 800;
	localparam int DRAIN_AT     = 1100;   // sender waits here until all windows are back
	localparam int SETTLE_CYCLES = 8;
	localparam int CYCLE_LIMIT  = 200000;

	logic   clk;
	logic   arst_n;
	logic   pixel_valid;
	logic   pixel_stall;
	field_t pixel;
	logic   window_valid;
	logic   window_stall;
	field_t tap_0, tap_1, tap_2, tap_3, tap_4, tap_5, tap_6, tap_7, tap_8;

	sliding_window_line_buffer dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.pixel_valid  (pixel_valid),
		.pixel_stall  (pixel_stall),
		.pixel        (pixel),
		.window_valid (window_valid),
		.window_stall (window_stall),
		.tap_0        (tap_0),
		.tap_1        (tap_1),
		.tap_2        (tap_2),
		.tap_3        (tap_3),
		.tap_4        (tap_4),
		.tap_5        (tap_5),
		.tap_6        (tap_6),
		.tap_7        (tap_7),
		.tap_8        (tap_8)
	);

	// predictor state: window registers, line stores and their shared position
	data_t       win_regs [MAX_ROWS][MAX_COLS];
	data_t       line_mem [STORE_ROWS][STORE_DEPTH];
	int unsigned line_pos;

	window_t     expected_windows [$];
	int          mismatches = 0;
	int          windows_taken = 0;
	int          cycle_count = 0;
	step_row_t   directed_rows [DIRECTED_N];

	// shift one pixel through the window and stores, return the updated window
	function automatic window_t slide_window(input field_t px);
		data_t   carry;
		data_t   held;
		window_t w;
		carry = data_t'(px);
		for (int r = 0; r < MAX_ROWS; r++) begin
			if (r < KERNEL_ROWS) begin
				for (int c = 0; c < MAX_COLS; c++) begin
					if (c < KERNEL_COLS) begin
						held = win_regs[r][c];
						win_regs[r][c] = carry;
						carry = held;
					end
				end
				// last tap of the row goes to the store tail, its head enters the next row
				if (HAS_STORE && r < KERNEL_ROWS - 1) begin
					held = line_mem[r][line_pos];
					line_mem[r][line_pos] = carry;
					carry = held;
				end
			end
		end
		// value leaving the last row is simply dropped
		if (HAS_STORE)
			line_pos = (line_pos + 1 >= STORE_DEPTH) ? 0 : line_pos + 1;
		for (int r = 0; r < MAX_ROWS; r++) begin
			for (int c = 0; c < MAX_COLS; c++) begin
				// taps outside a smaller window read zero
				w[r * MAX_COLS + c] = (r < KERNEL_ROWS && c < KERNEL_COLS) ?
					field_t'(win_regs[r][c]) : '0;
			end
		end
		return w;
	endfunction

	// shortly after reset the stores still read zero, so only row 0 carries data
	function automatic window_t newest_three(input field_t a, input field_t b, input field_t c);
		window_t w;
		w    = '0;
		w[0] = a;
		w[1] = b;
		w[2] = c;
		return w;
	endfunction

	// offer one pixel request and hold it until the block takes it
	task automatic offer_pixel(input field_t px, input bit typed, input window_t typed_want,
			input bit no_gaps);
		bit      taken;
		window_t predicted;
		if (!no_gaps) begin
			while ($urandom_range(0, 99) < 35) begin
				pixel_valid <= 1'b0;
				@(posedge clk);
			end
		end
		pixel_valid <= 1'b1;
		pixel       <= px;
		taken = 1'b0;
		// inputs are stable from the falling edge on, so the decision is race free there
		while (!taken) begin
			@(negedge clk);
			taken = !pixel_stall;
			@(posedge clk);
		end
		predicted = slide_window(px);
		expected_windows.push_back(typed ? typed_want : predicted);
	endtask

	task automatic note_mismatch(input string what, input int tap_idx, input field_t want,
			input field_t got);
		mismatches++;
		if (mismatches <= 10)
			$display("window %0d %s tap_%0d: expected %h, got %h", windows_taken, what,
				tap_idx, want, got);
	endtask

	// free-running clock, 4 ns period
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// run limit, counted in clock cycles
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// receiver: random stalls, one long hold-off, a quiet span with no stalls
	initial begin
		bit hold_done;
		hold_done    = 1'b0;
		window_stall <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!hold_done && windows_taken >= HOLD_AT) begin
				// sender keeps offering meanwhile, so the block fills and stalls its input
				hold_done = 1'b1;
				window_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (windows_taken >= QUIET_FROM && windows_taken < QUIET_TO) begin
				window_stall <= 1'b0;
			end else begin
				window_stall <= ($urandom_range(0, 99) < 35);
			end
		end
	end

	// checker: a window request is taken at the next rising edge when valid and not stalled
	always @(negedge clk) begin
		window_t got;
		window_t want;
		if (arst_n && window_valid === 1'b1 && window_stall === 1'b0) begin
			got = {tap_8, tap_7, tap_6, tap_5, tap_4, tap_3, tap_2, tap_1, tap_0};
			if (expected_windows.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("window %0d arrived with nothing expected: %h", windows_taken, got);
			end else begin
				want = expected_windows.pop_front();
				for (int k = 0; k < TAP_COUNT; k++)
					if (got[k] !== want[k])
						note_mismatch("mismatch on", k, want[k], got[k]);
			end
			windows_taken++;
		end
	end

	// reset, directed rows, random pixels, drain and verdict
	initial begin
		field_t px;
		bit     quiet;
		line_pos      = 0;
		for (int r = 0; r < MAX_ROWS; r++)
			for (int c = 0; c < MAX_COLS; c++)
				win_regs[r][c] = '0;
		for (int r = 0; r < STORE_ROWS; r++)
			for (int d = 0; d < STORE_DEPTH; d++)
				line_mem[r][d] = '0;

		// first rows read straight off: row 0 holds the last three pixels, rows 1 and 2 zero
		directed_rows = '{
			'{16'hFFFF, 1'b1, newest_three(16'hFFFF, 16'h0000, 16'h0000)},
			'{16'h0000, 1'b1, newest_three(16'h0000, 16'hFFFF, 16'h0000)},
			'{16'h8000, 1'b1, newest_three(16'h8000, 16'h0000, 16'hFFFF)},
			'{16'h0001, 1'b1, newest_three(16'h0001, 16'h8000, 16'h0000)},
			'{16'h5555, 1'b1, newest_three(16'h5555, 16'h0001, 16'h8000)},
			'{16'hAAAA, 1'b1, newest_three(16'hAAAA, 16'h5555, 16'h0001)},
			'{16'h00FF, 1'b1, newest_three(16'h00FF, 16'hAAAA, 16'h5555)},
			'{16'hFF00, 1'b1, newest_three(16'hFF00, 16'h00FF, 16'hAAAA)},
			'{16'h7FFF, 1'b1, newest_three(16'h7FFF, 16'hFF00, 16'h00FF)},
			'{16'hFFFE, 1'b1, newest_three(16'hFFFE, 16'h7FFF, 16'hFF00)},
			'{16'h1234, 1'b0, '0},
			'{16'h0F0F, 1'b0, '0},
			'{16'hF0F0, 1'b0, '0},
			'{16'h3C3C, 1'b0, '0},
			'{16'h0002, 1'b0, '0},
			'{16'h4000, 1'b0, '0},
			'{16'hFFFF, 1'b0, '0},
			'{16'hFFFF, 1'b0, '0},
			'{16'h0000, 1'b0, '0},
			'{16'h0000, 1'b0, '0}
		};

		arst_n      <= 1'b0;
		pixel_valid <= 1'b0;
		pixel       <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			offer_pixel(directed_rows[i].px, directed_rows[i].typed, directed_rows[i].want, 1'b0);

		// random stream, long enough to wrap the line stores many times over
		for (int n = 0; n < RANDOM_N; n++) begin
			if (n == DRAIN_AT) begin
				// sender pause until every window has come back
				pixel_valid <= 1'b0;
				while (expected_windows.size() != 0) @(posedge clk);
			end
			case ($urandom_range(0, 9))
				0:       px = '0;
				1:       px = '1;
				2:       px = field_t'(1) << $urandom_range(0, FIELD_W - 1);
				default: px = field_t'($urandom);
			endcase
			quiet = (n >= QUIET_FROM && n < QUIET_TO);
			offer_pixel(px, 1'b0, '0, quiet);
		end
		pixel_valid <= 1'b0;

		while (expected_windows.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

FILE: sim.f
rtl/swlb_pkg.sv
rtl/swlb_ram.sv
rtl/sliding_window_line_buffer.sv
tb/sliding_window_line_buffer_tb.sv
